// ===== rtl/core/sqvt_pkg.sv =====
`timescale 1ns / 1ps

package sqvt_pkg;

   // Field widths of the sprite and vertex beats
   localparam int POS_W     = 24;
   localparam int SIZE_W    = 23;
   localparam int TURN_W    = 16;
   localparam int TEX_W     = 16;
   localparam int RGBA_W    = 32;
   localparam int NDC_W     = 21;
   localparam int CORNER_W  = 2;
   localparam int VP_W      = 14;
   localparam int CSR_IDX_W = 1;

   // Internal arithmetic widths
   localparam int TRIG_W     = 32;             // Q2.30 sine and cosine
   localparam int TRIG_FRAC  = 30;
   localparam int CX_W       = SIZE_W + 2;     // size minus pivot
   localparam int PROD_W     = TRIG_W + CX_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int V_W        = 29;             // rotated and translated coordinate
   localparam int NDC_SHIFT  = 17;             // 2 * 2^16
   localparam int DIV_BITS   = NDC_W + 2;      // quotient bits, top one flags overflow
   localparam int NDC_CALC_W = NDC_W + 4;
   localparam int CORDIC_MAX = 24;
   localparam int NUM_VERTS  = 6;
   localparam int VIDX_W     = 3;

   // Parameter defaults
   localparam int DEF_ANGLE_BITS      = 16;
   localparam int DEF_COORD_FRAC_BITS = 8;
   localparam int DEF_TRIG_STAGES     = 16;

   localparam logic [VP_W-1:0] VP_WIDTH_RESET  = VP_W'(1920);
   localparam logic [VP_W-1:0] VP_HEIGHT_RESET = VP_W'(1080);

   localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 32'sh26DD3B6A;
   localparam logic signed [TRIG_W-1:0] TRIG_ONE  = 32'sh40000000;

   localparam logic signed [NDC_CALC_W-1:0] NDC_ONE = NDC_CALC_W'(65536);
   localparam logic signed [NDC_CALC_W-1:0] NDC_MAX = NDC_CALC_W'(1048575);
   localparam logic signed [NDC_CALC_W-1:0] NDC_MIN = -NDC_CALC_W'(1048576);

   localparam logic [VIDX_W-1:0] LAST_VIDX = VIDX_W'(NUM_VERTS - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VIEWPORT_WIDTH  = 1'b0,
      CSR_VIEWPORT_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [SIZE_W-1:0]       size_w;
      logic [SIZE_W-1:0]       size_h;
      logic signed [POS_W-1:0] pivot_x;
      logic signed [POS_W-1:0] pivot_y;
      logic [TEX_W-1:0]        u_begin;
      logic [TEX_W-1:0]        v_begin;
      logic [TEX_W-1:0]        u_end;
      logic [TEX_W-1:0]        v_end;
      logic [RGBA_W-1:0]       rgba;
   } sprite_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] x;
      logic signed [TRIG_W-1:0] y;
      logic signed [TRIG_W-1:0] z;
      logic                     neg;
      logic                     rot;
   } cordic_type;

   typedef struct packed {
      logic [CORNER_W-1:0] corner;
      logic [TEX_W-1:0]    tex_u;
      logic [TEX_W-1:0]    tex_v;
      logic [RGBA_W-1:0]   colour;
   } attr_type;

   typedef struct packed {
      logic [DIV_BITS-1:0] q_x;
      logic [DIV_BITS-1:0] q_y;
      logic                neg_x;
      logic                neg_y;
      attr_type            attr;
   } div_info_type;

   // Arctangent of 2^-i as a 32-bit binary angle
   function automatic logic [TRIG_W-1:0] atan_step(input int i);
      logic [TRIG_W-1:0] a;
      begin
         unique case (i)
            0:  a = 32'h20000000;
            1:  a = 32'h12E4051D;
            2:  a = 32'h09FB385B;
            3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;
            5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;
            7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;
            9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;
            11: a = 32'h000517CC;
            12: a = 32'h00028BE6;
            13: a = 32'h000145F3;
            14: a = 32'h0000A2F9;
            15: a = 32'h0000517C;
            16: a = 32'h000028BE;
            17: a = 32'h0000145F;
            18: a = 32'h00000A2F;
            19: a = 32'h00000517;
            20: a = 32'h0000028B;
            21: a = 32'h00000145;
            22: a = 32'h000000A2;
            23: a = 32'h00000051;
            default: a = '0;
         endcase
         return a;
      end
   endfunction

   // Triangle-list order 0,2,1 then 1,2,3
   function automatic logic [CORNER_W-1:0] tri_corner(input logic [VIDX_W-1:0] idx);
      logic [CORNER_W-1:0] c;
      begin
         unique case (idx)
            3'd0:    c = 2'd0;
            3'd1:    c = 2'd2;
            3'd2:    c = 2'd1;
            3'd3:    c = 2'd1;
            3'd4:    c = 2'd2;
            3'd5:    c = 2'd3;
            default: c = 2'd0;
         endcase
         return c;
      end
   endfunction

endpackage

// ===== rtl/core/sqvt_req_if.sv =====
`timescale 1ns / 1ps

interface sqvt_req_if
   import sqvt_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic [SIZE_W-1:0]       size_w;
   logic [SIZE_W-1:0]       size_h;
   logic signed [POS_W-1:0] pivot_x;
   logic signed [POS_W-1:0] pivot_y;
   logic [TURN_W-1:0]       turn;
   logic [TEX_W-1:0]        u_begin;
   logic [TEX_W-1:0]        v_begin;
   logic [TEX_W-1:0]        u_end;
   logic [TEX_W-1:0]        v_end;
   logic [RGBA_W-1:0]       rgba;

   modport source (output valid, pos_x, pos_y, size_w, size_h, pivot_x, pivot_y, turn,
                   u_begin, v_begin, u_end, v_end, rgba, input ready);
   modport sink   (input valid, pos_x, pos_y, size_w, size_h, pivot_x, pivot_y, turn,
                   u_begin, v_begin, u_end, v_end, rgba, output ready);
endinterface

// ===== rtl/core/sqvt_rsp_if.sv =====
`timescale 1ns / 1ps

interface sqvt_rsp_if
   import sqvt_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic signed [NDC_W-1:0] ndc_x;
   logic signed [NDC_W-1:0] ndc_y;
   logic [TEX_W-1:0]        tex_u;
   logic [TEX_W-1:0]        tex_v;
   logic [RGBA_W-1:0]       colour_out;
   logic [CORNER_W-1:0]     corner;
   logic                    last;

   modport source (output valid, ndc_x, ndc_y, tex_u, tex_v, colour_out, corner, last,
                   input ready);
   modport sink   (input valid, ndc_x, ndc_y, tex_u, tex_v, colour_out, corner, last,
                   output ready);
endinterface

// ===== rtl/core/sprite_quad_vertex_transform.sv =====
`timescale 1ns / 1ps
// Each sprite leaves as six vertex beats, one per cycle while the response side is ready.
// The CORDIC chain takes a new sprite only when the corner expander is empty or passes on
// its last corner; the 23-cell divider chain takes a new corner every cycle unless the
// collector stalls; a four-corner collector in front of the emitter absorbs the difference.
// Reset: synchronous, active high; clears all valid bits, viewport returns to 1920 x 1080.

module sprite_quad_vertex_transform
   import sqvt_pkg::*;
#(
   parameter int ANGLE_BITS      = DEF_ANGLE_BITS,
   parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
   parameter int TRIG_STAGES     = DEF_TRIG_STAGES
) (
   input  logic                 clock,
   input  logic                 reset,
   sqvt_req_if.sink             req_chan,
   sqvt_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VP_W-1:0]      csr_wdata
);

   localparam int DEN_W = VP_W + COORD_FRAC_BITS;
   localparam int NUM_W = V_W + NDC_SHIFT + 1;
   localparam int REM_W = ((NUM_W > DEN_W + DIV_BITS) ? NUM_W : DEN_W + DIV_BITS) + 1;

   logic [VP_W-1:0]  vp_w_ff, vp_h_ff, dim_x, dim_y;
   logic [DEN_W-1:0] den_x, den_y;

   // Viewport registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vp_w_ff <= VP_WIDTH_RESET;
         vp_h_ff <= VP_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VIEWPORT_WIDTH:  vp_w_ff <= csr_wdata;
            CSR_VIEWPORT_HEIGHT: vp_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      dim_x = (vp_w_ff == '0) ? VP_W'(1) : vp_w_ff;
      dim_y = (vp_h_ff == '0) ? VP_W'(1) : vp_h_ff;
      den_x = DEN_W'(dim_x) << COORD_FRAC_BITS;
      den_y = DEN_W'(dim_y) << COORD_FRAC_BITS;
   end

   // Angle prep: fold second and third quadrant by half a turn
   logic              cordic_valid [TRIG_STAGES+1];
   cordic_type        cordic_link  [TRIG_STAGES+1];
   sprite_type        sprite_link  [TRIG_STAGES+1];
   logic [TRIG_W-1:0] ang_t, ang_a;
   logic              ang_neg;
   logic              adv_c, adv_p;

   always_comb begin
      ang_t   = TRIG_W'(req_chan.turn) & ((TRIG_W'(1) << ANGLE_BITS) - TRIG_W'(1));
      ang_a   = ang_t << (TRIG_W - ANGLE_BITS);
      ang_neg = ang_a[TRIG_W-1] ^ ang_a[TRIG_W-2];
      if (ang_neg) ang_a = ang_a + {1'b1, {(TRIG_W-1){1'b0}}};
      cordic_valid[0]     = req_chan.valid;
      cordic_link[0].x    = CORDIC_X0;
      cordic_link[0].y    = '0;
      cordic_link[0].z    = $signed(ang_a);
      cordic_link[0].neg  = ang_neg;
      cordic_link[0].rot  = ang_t != '0;
      sprite_link[0].pos_x   = req_chan.pos_x;
      sprite_link[0].pos_y   = req_chan.pos_y;
      sprite_link[0].size_w  = req_chan.size_w;
      sprite_link[0].size_h  = req_chan.size_h;
      sprite_link[0].pivot_x = req_chan.pivot_x;
      sprite_link[0].pivot_y = req_chan.pivot_y;
      sprite_link[0].u_begin = req_chan.u_begin;
      sprite_link[0].v_begin = req_chan.v_begin;
      sprite_link[0].u_end   = req_chan.u_end;
      sprite_link[0].v_end   = req_chan.v_end;
      sprite_link[0].rgba    = req_chan.rgba;
   end

   assign req_chan.ready = adv_c;

   for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_cordic
      sqvt_cordic_cell #(.STAGE(i)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .adv        (adv_c),
         .src_valid  (cordic_valid[i]),
         .src_state  (cordic_link[i]),
         .src_sprite (sprite_link[i]),
         .dst_valid  (cordic_valid[i+1]),
         .dst_state  (cordic_link[i+1]),
         .dst_sprite (sprite_link[i+1])
      );
   end

   // Corner expander: hold one sprite, issue four corners
   logic                     exp_valid_ff;
   logic [CORNER_W-1:0]      exp_cnt_ff;
   sprite_type               exp_sprite_ff;
   logic signed [TRIG_W-1:0] exp_cs_ff, exp_sn_ff, cs_in, sn_in;
   cordic_type               cend;

   always_comb begin
      cend  = cordic_link[TRIG_STAGES];
      adv_c = !exp_valid_ff || (exp_cnt_ff == CORNER_W'(3) && adv_p);
      if (!cend.rot) begin
         cs_in = TRIG_ONE;
         sn_in = '0;
      end else if (cend.neg) begin
         cs_in = -cend.x;
         sn_in = -cend.y;
      end else begin
         cs_in = cend.x;
         sn_in = cend.y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_valid_ff <= 1'b0;
         exp_cnt_ff   <= '0;
      end else if (adv_c) begin
         exp_valid_ff <= cordic_valid[TRIG_STAGES];
         exp_cnt_ff   <= '0;
      end else if (adv_p) begin
         exp_cnt_ff   <= exp_cnt_ff + CORNER_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (adv_c) begin
         exp_sprite_ff <= sprite_link[TRIG_STAGES];
         exp_cs_ff     <= cs_in;
         exp_sn_ff     <= sn_in;
      end
   end

   // Stage E: corner offsets from the pivot
   logic                     e_valid_ff;
   logic signed [CX_W-1:0]   e_cx_ff, e_cy_ff, e_cx_in, e_cy_in;
   logic signed [TRIG_W-1:0] e_cs_ff, e_sn_ff;
   logic signed [POS_W-1:0]  e_px_ff, e_py_ff;
   attr_type                 e_attr_ff, e_attr_in;

   always_comb begin
      e_cx_in = (exp_cnt_ff[0] ? $signed(CX_W'(exp_sprite_ff.size_w)) : '0)
                - CX_W'($signed(exp_sprite_ff.pivot_x));
      e_cy_in = (exp_cnt_ff[1] ? $signed(CX_W'(exp_sprite_ff.size_h)) : '0)
                - CX_W'($signed(exp_sprite_ff.pivot_y));
      e_attr_in.corner = exp_cnt_ff;
      e_attr_in.tex_u  = exp_cnt_ff[0] ? exp_sprite_ff.u_end : exp_sprite_ff.u_begin;
      e_attr_in.tex_v  = exp_cnt_ff[1] ? exp_sprite_ff.v_end : exp_sprite_ff.v_begin;
      e_attr_in.colour = exp_sprite_ff.rgba;
   end

   // Stage M: rotation products
   logic                     m_valid_ff;
   logic signed [PROD_W-1:0] m_xc_ff, m_ys_ff, m_xs_ff, m_yc_ff;
   logic signed [POS_W-1:0]  m_px_ff, m_py_ff;
   attr_type                 m_attr_ff;

   // Stage A: rounded rotation sums
   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (TRIG_FRAC - 1);
   logic                     a_valid_ff;
   logic signed [SUM_W-1:0]  a_sx_ff, a_sy_ff;
   logic signed [POS_W-1:0]  a_px_ff, a_py_ff;
   attr_type                 a_attr_ff;

   // Stage B: translate by position
   logic                     b_valid_ff;
   logic signed [V_W-1:0]    b_vx_ff, b_vy_ff;
   attr_type                 b_attr_ff;

   // Stage C: divider numerator magnitude
   logic                     c_valid_ff;
   logic [REM_W-1:0]         c_rx_ff, c_ry_ff, c_rx_in, c_ry_in;
   logic                     c_nx_ff, c_ny_ff;
   attr_type                 c_attr_ff;
   logic signed [NUM_W-1:0]  num_x, num_y;

   always_comb begin
      num_x   = (NUM_W'(b_vx_ff) <<< NDC_SHIFT) + $signed(NUM_W'(den_x >> 1));
      num_y   = (NUM_W'(b_vy_ff) <<< NDC_SHIFT) + $signed(NUM_W'(den_y >> 1));
      c_rx_in = num_x[NUM_W-1] ? REM_W'(den_x) - REM_W'(1) - REM_W'(num_x) : REM_W'(num_x);
      c_ry_in = num_y[NUM_W-1] ? REM_W'(den_y) - REM_W'(1) - REM_W'(num_y) : REM_W'(num_y);
   end

   // Advance valid bits of the corner stages
   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (adv_p) begin
         e_valid_ff <= exp_valid_ff;
         m_valid_ff <= e_valid_ff;
         a_valid_ff <= m_valid_ff;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_p) begin
         e_cx_ff   <= e_cx_in;
         e_cy_ff   <= e_cy_in;
         e_cs_ff   <= exp_cs_ff;
         e_sn_ff   <= exp_sn_ff;
         e_px_ff   <= exp_sprite_ff.pos_x;
         e_py_ff   <= exp_sprite_ff.pos_y;
         e_attr_ff <= e_attr_in;

         m_xc_ff   <= e_cs_ff * e_cx_ff;
         m_ys_ff   <= e_sn_ff * e_cy_ff;
         m_xs_ff   <= e_sn_ff * e_cx_ff;
         m_yc_ff   <= e_cs_ff * e_cy_ff;
         m_px_ff   <= e_px_ff;
         m_py_ff   <= e_py_ff;
         m_attr_ff <= e_attr_ff;

         a_sx_ff   <= SUM_W'(m_xc_ff) - SUM_W'(m_ys_ff) + ROUND_HALF;
         a_sy_ff   <= SUM_W'(m_xs_ff) + SUM_W'(m_yc_ff) + ROUND_HALF;
         a_px_ff   <= m_px_ff;
         a_py_ff   <= m_py_ff;
         a_attr_ff <= m_attr_ff;

         b_vx_ff   <= V_W'(a_sx_ff >>> TRIG_FRAC) + V_W'(a_px_ff);
         b_vy_ff   <= V_W'(a_sy_ff >>> TRIG_FRAC) + V_W'(a_py_ff);
         b_attr_ff <= a_attr_ff;

         c_rx_ff   <= c_rx_in;
         c_ry_ff   <= c_ry_in;
         c_nx_ff   <= num_x[NUM_W-1];
         c_ny_ff   <= num_y[NUM_W-1];
         c_attr_ff <= b_attr_ff;
      end
   end

   // Divider chain, most significant quotient bit first
   logic             div_valid [DIV_BITS+1];
   logic [REM_W-1:0] div_rx    [DIV_BITS+1];
   logic [REM_W-1:0] div_ry    [DIV_BITS+1];
   div_info_type     div_info  [DIV_BITS+1];

   always_comb begin
      div_valid[0]      = c_valid_ff;
      div_rx[0]         = c_rx_ff;
      div_ry[0]         = c_ry_ff;
      div_info[0].q_x   = '0;
      div_info[0].q_y   = '0;
      div_info[0].neg_x = c_nx_ff;
      div_info[0].neg_y = c_ny_ff;
      div_info[0].attr  = c_attr_ff;
   end

   for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
      sqvt_div_cell #(
         .BIT   (DIV_BITS - 1 - j),
         .REM_W (REM_W),
         .DEN_W (DEN_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv_p),
         .den_x     (den_x),
         .den_y     (den_y),
         .src_valid (div_valid[j]),
         .src_rem_x (div_rx[j]),
         .src_rem_y (div_ry[j]),
         .src_info  (div_info[j]),
         .dst_valid (div_valid[j+1]),
         .dst_rem_x (div_rx[j+1]),
         .dst_rem_y (div_ry[j+1]),
         .dst_info  (div_info[j+1])
      );
   end

   sqvt_vertex_out u_out (
      .clock     (clock),
      .reset     (reset),
      .src_valid (div_valid[DIV_BITS]),
      .src_info  (div_info[DIV_BITS]),
      .adv       (adv_p),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== rtl/core/sqvt_cordic_cell.sv =====
`timescale 1ns / 1ps

module sqvt_cordic_cell
   import sqvt_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       adv,
   input  logic       src_valid,
   input  cordic_type src_state,
   input  sprite_type src_sprite,
   output logic       dst_valid,
   output cordic_type dst_state,
   output sprite_type dst_sprite
);

   logic signed [TRIG_W-1:0] xs, ys, zs, dx, dy, ang;
   cordic_type state_in;
   cordic_type state_ff;
   sprite_type sprite_ff;
   logic       valid_ff;

   // One micro-rotation toward zero residual angle
   always_comb begin
      xs  = src_state.x;
      ys  = src_state.y;
      zs  = src_state.z;
      dx  = ys >>> STAGE;
      dy  = xs >>> STAGE;
      ang = $signed(atan_step(STAGE));
      state_in = src_state;
      if (!zs[TRIG_W-1]) begin
         state_in.x = xs - dx;
         state_in.y = ys + dy;
         state_in.z = zs - ang;
      end else begin
         state_in.x = xs + dx;
         state_in.y = ys - dy;
         state_in.z = zs + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         state_ff  <= state_in;
         sprite_ff <= src_sprite;
      end
   end

   assign dst_valid  = valid_ff;
   assign dst_state  = state_ff;
   assign dst_sprite = sprite_ff;

endmodule

// ===== rtl/core/sqvt_div_cell.sv =====
`timescale 1ns / 1ps

module sqvt_div_cell
   import sqvt_pkg::*;
#(
   parameter int BIT   = 0,
   parameter int REM_W = 48,
   parameter int DEN_W = 22
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic [DEN_W-1:0]   den_x,
   input  logic [DEN_W-1:0]   den_y,
   input  logic               src_valid,
   input  logic [REM_W-1:0]   src_rem_x,
   input  logic [REM_W-1:0]   src_rem_y,
   input  div_info_type       src_info,
   output logic               dst_valid,
   output logic [REM_W-1:0]   dst_rem_x,
   output logic [REM_W-1:0]   dst_rem_y,
   output div_info_type       dst_info
);

   logic [REM_W-1:0] sh_x, sh_y, rem_x_in, rem_y_in, rem_x_ff, rem_y_ff;
   logic             take_x, take_y, valid_ff;
   div_info_type     info_in, info_ff;

   // Resolve one quotient bit per lane
   always_comb begin
      sh_x     = REM_W'(den_x) << BIT;
      sh_y     = REM_W'(den_y) << BIT;
      take_x   = src_rem_x >= sh_x;
      take_y   = src_rem_y >= sh_y;
      rem_x_in = take_x ? src_rem_x - sh_x : src_rem_x;
      rem_y_in = take_y ? src_rem_y - sh_y : src_rem_y;
      info_in  = src_info;
      info_in.q_x[BIT] = take_x;
      info_in.q_y[BIT] = take_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
         info_ff  <= info_in;
      end
   end

   assign dst_valid = valid_ff;
   assign dst_rem_x = rem_x_ff;
   assign dst_rem_y = rem_y_ff;
   assign dst_info  = info_ff;

endmodule

// ===== rtl/core/sqvt_vertex_out.sv =====
`timescale 1ns / 1ps

module sqvt_vertex_out
   import sqvt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         src_valid,
   input  div_info_type src_info,
   output logic         adv,
   sqvt_rsp_if.source   rsp_chan
);

   logic signed [NDC_W-1:0] col_x_ff [4];
   logic signed [NDC_W-1:0] col_y_ff [4];
   attr_type                col_attr_ff [4];
   logic signed [NDC_W-1:0] em_x_ff [4];
   logic signed [NDC_W-1:0] em_y_ff [4];
   attr_type                em_attr_ff [4];
   logic                    col_full_ff, col_full_in;
   logic [CORNER_W-1:0]     col_next_ff;
   logic                    em_valid_ff;
   logic [VIDX_W-1:0]       em_idx_ff;
   logic                    emit_take, col_write;
   logic signed [NDC_W-1:0] ndc_x_in, ndc_y_in;
   logic [CORNER_W-1:0]     out_c;

   // Sign, offset by one and saturate a quotient
   function automatic logic signed [NDC_W-1:0] ndc_clamp(input logic [DIV_BITS-1:0] q,
                                                          input logic neg,
                                                          input logic flip);
      logic signed [NDC_CALC_W-1:0] qs, t, r;
      begin
         qs = NDC_CALC_W'(q[DIV_BITS-2:0]);
         if (neg) qs = -qs;
         t = flip ? NDC_ONE - qs : qs - NDC_ONE;
         priority if (q[DIV_BITS-1]) r = (neg ^ flip) ? NDC_MIN : NDC_MAX;
         else if (t > NDC_MAX)        r = NDC_MAX;
         else if (t < NDC_MIN)        r = NDC_MIN;
         else                         r = t;
         return NDC_W'(r);
      end
   endfunction

   always_comb begin
      ndc_x_in    = ndc_clamp(src_info.q_x, src_info.neg_x, 1'b0);
      ndc_y_in    = ndc_clamp(src_info.q_y, src_info.neg_y, 1'b1);
      emit_take   = !em_valid_ff || (rsp_chan.ready && em_idx_ff == LAST_VIDX);
      adv         = !(col_full_ff && !emit_take);
      col_write   = adv && src_valid;
      col_full_in = (col_full_ff && !emit_take) ||
                    (col_write && src_info.attr.corner == CORNER_W'(3));
   end

   // Gather four corners
   always_ff @(posedge clock) begin
      if (reset) begin
         col_full_ff <= 1'b0;
         col_next_ff <= '0;
      end else begin
         col_full_ff <= col_full_in;
         if (col_write) col_next_ff <= col_next_ff + CORNER_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (col_write) begin
         col_x_ff[src_info.attr.corner]    <= ndc_x_in;
         col_y_ff[src_info.attr.corner]    <= ndc_y_in;
         col_attr_ff[src_info.attr.corner] <= src_info.attr;
      end
   end

   // Emit six beats per sprite
   always_ff @(posedge clock) begin
      if (reset) begin
         em_valid_ff <= 1'b0;
         em_idx_ff   <= '0;
      end else if (emit_take) begin
         em_valid_ff <= col_full_ff;
         em_idx_ff   <= '0;
      end else if (rsp_chan.ready) begin
         em_idx_ff   <= em_idx_ff + VIDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (emit_take && col_full_ff) begin
         em_x_ff    <= col_x_ff;
         em_y_ff    <= col_y_ff;
         em_attr_ff <= col_attr_ff;
      end
   end

   assign out_c               = tri_corner(em_idx_ff);
   assign rsp_chan.valid      = em_valid_ff;
   assign rsp_chan.ndc_x      = em_x_ff[out_c];
   assign rsp_chan.ndc_y      = em_y_ff[out_c];
   assign rsp_chan.tex_u      = em_attr_ff[out_c].tex_u;
   assign rsp_chan.tex_v      = em_attr_ff[out_c].tex_v;
   assign rsp_chan.colour_out = em_attr_ff[out_c].colour;
   assign rsp_chan.corner     = out_c;
   assign rsp_chan.last       = em_idx_ff == LAST_VIDX;

   a_corner_order: assert property (@(posedge clock) disable iff (reset)
      col_write |-> src_info.attr.corner == col_next_ff)
      else $error("corner arrived out of order");

   a_sprite_wrap: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && em_idx_ff == LAST_VIDX) |=>
      (!em_valid_ff || em_idx_ff == '0))
      else $error("emitter did not restart after last beat");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !adv |-> (col_full_ff && em_valid_ff))
      else $error("pipeline stalled without a full collector");

   a_full_aligned: assert property (@(posedge clock) disable iff (reset)
      col_full_ff |-> col_next_ff == '0)
      else $error("collector full with partial corner count");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import sqvt_pkg::*;

   // One sprite beat, angle included
   typedef struct {
      sprite_type        spr;
      logic [TURN_W-1:0] turn;
   } sprite_beat_type;

   // Directed row: the corner 0 position is typed in where it is obvious
   typedef struct {
      sprite_beat_type         beat;
      bit                      typed;
      logic signed [NDC_W-1:0] tl_x;
      logic signed [NDC_W-1:0] tl_y;
   } directed_row_type;

   typedef struct {
      logic signed [NDC_W-1:0] ndc_x;
      logic signed [NDC_W-1:0] ndc_y;
      logic [TEX_W-1:0]        tex_u;
      logic [TEX_W-1:0]        tex_v;
      logic [RGBA_W-1:0]       colour;
      logic [CORNER_W-1:0]     corner;
      logic                    last;
   } vertex_beat_type;

   localparam int NUM_ROWS = 13;

   localparam longint ARC_TAB [16] = '{
      64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C};

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [VP_W-1:0] csr_wdata;

   sqvt_req_if req_bus ();
   sqvt_rsp_if rsp_bus ();

   sprite_quad_vertex_transform u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   vertex_beat_type pending_verts[$];
   logic [VP_W-1:0] vp_w_model;
   logic [VP_W-1:0] vp_h_model;
   int  errors;
   bit  no_idle;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // floor division, positive divisor
   function automatic longint floor_div(input longint n, input longint d);
      if (n >= 0) return n / d;
      return -(((-n) + d - 1) / d);
   endfunction

   function automatic longint to_ndc(input longint v, input logic [VP_W-1:0] dim);
      longint den;
      den = (dim == 0) ? 256 : longint'(dim) << 8;
      return floor_div(v * 131072 + den / 2, den);
   endfunction

   function automatic longint clamp_ndc(input longint v);
      if (v > 1048575) return 1048575;
      if (v < -1048576) return -1048576;
      return v;
   endfunction

   // Expected six vertices of one sprite, in triangle-list order
   function automatic void predict_vertices(input sprite_beat_type b);
      logic [31:0]     ang;
      bit              flip;
      longint          x, y, z, dx, dy, cs, sn, cx, cy, rx, ry;
      longint          qx [4];
      longint          qy [4];
      int              order [6];
      vertex_beat_type vb;
      int              c;
      order = '{0, 2, 1, 1, 2, 3};
      cs = 0;
      sn = 0;
      if (b.turn != 0) begin
         ang = {b.turn, 16'h0};
         flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
         if (flip) ang = ang + 32'h80000000;
         z = longint'(signed'(ang));
         x = 64'h26DD3B6A;
         y = 0;
         for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx; y = y + dy; z = z - ARC_TAB[i];
            end else begin
               x = x + dx; y = y - dy; z = z + ARC_TAB[i];
            end
         end
         cs = flip ? -x : x;
         sn = flip ? -y : y;
      end
      for (int k = 0; k < 4; k++) begin
         cx = ((k & 1) ? longint'(b.spr.size_w) : 0) - longint'(b.spr.pivot_x);
         cy = ((k & 2) ? longint'(b.spr.size_h) : 0) - longint'(b.spr.pivot_y);
         if (b.turn != 0) begin
            rx = (cs * cx - sn * cy + (64'sd1 << 29)) >>> 30;
            ry = (sn * cx + cs * cy + (64'sd1 << 29)) >>> 30;
            cx = rx;
            cy = ry;
         end
         cx = cx + longint'(b.spr.pos_x);
         cy = cy + longint'(b.spr.pos_y);
         qx[k] = clamp_ndc(to_ndc(cx, vp_w_model) - 65536);
         qy[k] = clamp_ndc(65536 - to_ndc(cy, vp_h_model));
      end
      for (int k = 0; k < 6; k++) begin
         c = order[k];
         vb.ndc_x  = NDC_W'(qx[c]);
         vb.ndc_y  = NDC_W'(qy[c]);
         vb.tex_u  = (c & 1) ? b.spr.u_end : b.spr.u_begin;
         vb.tex_v  = (c & 2) ? b.spr.v_end : b.spr.v_begin;
         vb.colour = b.spr.rgba;
         vb.corner = CORNER_W'(c);
         vb.last   = (k == 5);
         pending_verts = {pending_verts, vb};
      end
   endfunction

   // Random sprite: mostly modest sizes, sometimes the full field range
   function automatic sprite_beat_type random_sprite();
      sprite_beat_type b;
      bit wide;
      wide = ($urandom_range(0, 3) == 0);
      b.spr.pos_x   = POS_W'(wide ? $urandom : $urandom_range(0, 1048575) - 524288);
      b.spr.pos_y   = POS_W'(wide ? $urandom : $urandom_range(0, 1048575) - 524288);
      b.spr.size_w  = SIZE_W'(wide ? $urandom : $urandom_range(0, 131071));
      b.spr.size_h  = SIZE_W'(wide ? $urandom : $urandom_range(0, 131071));
      b.spr.pivot_x = POS_W'(wide ? $urandom : $urandom_range(0, 65535) - 16384);
      b.spr.pivot_y = POS_W'(wide ? $urandom : $urandom_range(0, 65535) - 16384);
      b.turn        = TURN_W'(($urandom_range(0, 7) == 0) ? 0 : $urandom);
      b.spr.u_begin = TEX_W'(($urandom_range(0, 7) == 0) ? $urandom
                                                          : $urandom_range(0, 32768));
      b.spr.v_begin = TEX_W'(($urandom_range(0, 7) == 0) ? $urandom
                                                          : $urandom_range(0, 32768));
      b.spr.u_end   = TEX_W'(($urandom_range(0, 7) == 0) ? $urandom
                                                          : $urandom_range(0, 32768));
      b.spr.v_end   = TEX_W'(($urandom_range(0, 7) == 0) ? $urandom
                                                          : $urandom_range(0, 32768));
      b.spr.rgba    = $urandom;
      return b;
   endfunction

   function automatic sprite_beat_type make_sprite(input int px, input int py, input int w,
                                                    input int h, input int ox, input int oy,
                                                    input int t, input int tex,
                                                    input int col);
      sprite_beat_type b;
      b.spr.pos_x   = POS_W'(px);
      b.spr.pos_y   = POS_W'(py);
      b.spr.size_w  = SIZE_W'(w);
      b.spr.size_h  = SIZE_W'(h);
      b.spr.pivot_x = POS_W'(ox);
      b.spr.pivot_y = POS_W'(oy);
      b.turn        = TURN_W'(t);
      b.spr.u_begin = TEX_W'(tex);
      b.spr.v_begin = TEX_W'(tex + 1);
      b.spr.u_end   = TEX_W'(tex + 2);
      b.spr.v_end   = TEX_W'(tex + 3);
      b.spr.rgba    = RGBA_W'(col);
      return b;
   endfunction

   // Drive one sprite beat after a random gap unless no_idle is set; log its vertices on acceptance
   task automatic send_sprite(input sprite_beat_type b, input bit typed,
                              input logic signed [NDC_W-1:0] tl_x,
                              input logic signed [NDC_W-1:0] tl_y);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.pos_x   <= b.spr.pos_x;
      req_bus.pos_y   <= b.spr.pos_y;
      req_bus.size_w  <= b.spr.size_w;
      req_bus.size_h  <= b.spr.size_h;
      req_bus.pivot_x <= b.spr.pivot_x;
      req_bus.pivot_y <= b.spr.pivot_y;
      req_bus.turn    <= b.turn;
      req_bus.u_begin <= b.spr.u_begin;
      req_bus.v_begin <= b.spr.v_begin;
      req_bus.u_end   <= b.spr.u_end;
      req_bus.v_end   <= b.spr.v_end;
      req_bus.rgba    <= b.spr.rgba;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      predict_vertices(b);
      if (typed) begin
         // corner 0 leads the first triangle
         pending_verts[pending_verts.size() - 6].ndc_x = tl_x;
         pending_verts[pending_verts.size() - 6].ndc_y = tl_y;
      end
   endtask

   // Write a viewport register once the pipeline has drained
   task automatic set_viewport(input csr_index_type idx, input int value);
      req_bus.valid <= 1'b0;
      wait (pending_verts.size() == 0);
      repeat (60) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= VP_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_VIEWPORT_WIDTH) vp_w_model = VP_W'(value);
      else vp_h_model = VP_W'(value);
   endtask

   // Check each vertex beat and draw the next stall
   int stall_left;
   always @(posedge clock) begin
      vertex_beat_type ev;
      if (reset) begin
         stall_left = 0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         if (pending_verts.size() == 0) begin
            errors++;
            $display("%0t: vertex beat with nothing expected, ndc %0d,%0d corner %0d",
                     $time, rsp_bus.ndc_x, rsp_bus.ndc_y, rsp_bus.corner);
         end else begin
            ev = pending_verts.pop_front();
            if (rsp_bus.ndc_x !== ev.ndc_x || rsp_bus.ndc_y !== ev.ndc_y ||
                rsp_bus.tex_u !== ev.tex_u || rsp_bus.tex_v !== ev.tex_v ||
                rsp_bus.colour_out !== ev.colour || rsp_bus.corner !== ev.corner ||
                rsp_bus.last !== ev.last) begin
               errors++;
               $display("%0t: expected x %0d y %0d u %h v %h rgba %h c %0d l %0b", $time,
                        ev.ndc_x, ev.ndc_y, ev.tex_u, ev.tex_v, ev.colour, ev.corner,
                        ev.last);
               $display("%0t: actual   x %0d y %0d u %h v %h rgba %h c %0d l %0b", $time,
                        rsp_bus.ndc_x, rsp_bus.ndc_y, rsp_bus.tex_u, rsp_bus.tex_v,
                        rsp_bus.colour_out, rsp_bus.corner, rsp_bus.last);
            end
         end
         stall_left = no_idle ? 0 : $urandom_range(0, 11);
      end else if (stall_left > 0) begin
         stall_left--;
      end
      rsp_bus.ready <= !reset && (stall_left == 0);
   end

   directed_row_type rows [NUM_ROWS];
   int vp_plan [5][2] = '{'{1920, 1080}, '{1, 1}, '{0, 16383}, '{8192, 8192},
                          '{640, 480}};

   initial begin
      errors     = 0;
      no_idle    = 0;
      vp_w_model = 1920;
      vp_h_model = 1080;
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = CSR_VIEWPORT_WIDTH;
      csr_wdata  = '0;
      req_bus.valid = 1'b0;
      {req_bus.pos_x, req_bus.pos_y, req_bus.size_w, req_bus.size_h} = '0;
      {req_bus.pivot_x, req_bus.pivot_y, req_bus.turn, req_bus.rgba} = '0;
      {req_bus.u_begin, req_bus.v_begin, req_bus.u_end, req_bus.v_end} = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table at the reset viewport
      rows[0]  = '{make_sprite(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                   NDC_W'(-65536), NDC_W'(65536)};
      rows[1]  = '{make_sprite(8388607, 8388607, 0, 0, 0, 0, 0, 32768, -1), 1'b1,
                   NDC_W'(1048575), NDC_W'(-1048576)};
      rows[2]  = '{make_sprite(-8388608, -8388608, 0, 0, 0, 0, 0, 65532, 0), 1'b1,
                   NDC_W'(-1048576), NDC_W'(1048575)};
      rows[3]  = '{make_sprite(0, 0, 8388607, 8388607, 0, 0, 0, 0, 1), 1'b1,
                   NDC_W'(-65536), NDC_W'(65536)};
      rows[4]  = '{make_sprite(0, 0, 0, 0, 8388607, 8388607, 0, 0, 2), 1'b0, '0, '0};
      rows[5]  = '{make_sprite(0, 0, 0, 0, -8388608, -8388608, 0, 0, 3), 1'b0, '0, '0};
      rows[6]  = '{make_sprite(245760, 138240, 16384, 8192, 8192, 4096, 1, 100, 4),
                   1'b0, '0, '0};
      rows[7]  = '{make_sprite(245760, 138240, 16384, 8192, 8192, 4096, 16384, 7, 5),
                   1'b0, '0, '0};
      rows[8]  = '{make_sprite(245760, 138240, 16384, 8192, 8192, 4096, 32768, 7, 6),
                   1'b0, '0, '0};
      rows[9]  = '{make_sprite(245760, 138240, 16384, 8192, 8192, 4096, 49152, 7, 7),
                   1'b0, '0, '0};
      rows[10] = '{make_sprite(245760, 138240, 16384, 8192, 0, 0, 65535, 7, 8),
                   1'b0, '0, '0};
      rows[11] = '{make_sprite(100000, -100000, 8388607, 8388607, -8388608, 8388607,
                               12345, 32760, 9), 1'b0, '0, '0};
      rows[12] = '{make_sprite(-5000, 5000, 2560, 2560, 1280, 1280, 8192, 0, 10),
                   1'b0, '0, '0};
      foreach (rows[i]) send_sprite(rows[i].beat, rows[i].typed, rows[i].tl_x, rows[i].tl_y);

      // Random phases, one viewport setting each
      for (int p = 0; p < 5; p++) begin
         set_viewport(CSR_VIEWPORT_WIDTH, vp_plan[p][0]);
         set_viewport(CSR_VIEWPORT_HEIGHT, vp_plan[p][1]);
         for (int n = 0; n < 48; n++) begin
            no_idle = (n >= 20 && n < 32);
            send_sprite(random_sprite(), 1'b0, '0, '0);
         end
         no_idle = 0;
      end
      req_bus.valid <= 1'b0;

      // Drain, then let the pipeline settle
      wait (pending_verts.size() == 0);
      repeat (60) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #3000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/sqvt_pkg.sv
rtl/core/sqvt_req_if.sv
rtl/core/sqvt_rsp_if.sv
rtl/core/sqvt_cordic_cell.sv
rtl/core/sqvt_div_cell.sv
rtl/core/sqvt_vertex_out.sv
rtl/core/sprite_quad_vertex_transform.sv
tb/testbench.sv
